FILE: rtl/core/fss_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and helpers for the flash stimulus sequencer.
package fss_pkg;

    localparam int MAX_GRID = 16;

    localparam logic [39:0] MIN_REST   = 40'd42949672;
    localparam logic [15:0] LFSR_SEED  = 16'hACE1;
    localparam logic [15:0] LFSR_TAPS  = 16'hB400;

    localparam logic OP_TICK = 1'b0;

    localparam logic [2:0] CFG_GRID       = 3'd0;
    localparam logic [2:0] CFG_REPS       = 3'd1;
    localparam logic [2:0] CFG_LIMIT      = 3'd2;
    localparam logic [2:0] CFG_FLASH      = 3'd3;
    localparam logic [2:0] CFG_DARK       = 3'd4;
    localparam logic [2:0] CFG_REP_REST   = 3'd5;
    localparam logic [2:0] CFG_TRIAL_REST = 3'd6;
    localparam logic [2:0] CFG_START      = 3'd7;

    localparam logic [2:0] PH_NONE      = 3'd0;
    localparam logic [2:0] PH_FLASH     = 3'd1;
    localparam logic [2:0] PH_DARK      = 3'd2;
    localparam logic [2:0] PH_REPREST   = 3'd3;
    localparam logic [2:0] PH_TRIALREST = 3'd4;

    localparam logic [3:0] EV_EXP_START   = 4'd0;
    localparam logic [3:0] EV_EXP_STOP    = 4'd1;
    localparam logic [3:0] EV_TRIAL_START = 4'd2;
    localparam logic [3:0] EV_TRIAL_STOP  = 4'd3;
    localparam logic [3:0] EV_SEG_START   = 4'd4;
    localparam logic [3:0] EV_SEG_STOP    = 4'd5;
    localparam logic [3:0] EV_REST_START  = 4'd6;
    localparam logic [3:0] EV_REST_STOP   = 4'd7;
    localparam logic [3:0] EV_FLASH_ON    = 4'd8;
    localparam logic [3:0] EV_FLASH_OFF   = 4'd9;
    localparam logic [3:0] EV_ROW_LABEL   = 4'd10;
    localparam logic [3:0] EV_COL_LABEL   = 4'd11;

    typedef struct packed {
        logic [4:0]  grid_size;
        logic [7:0]  repetitions_per_trial;
        logic [15:0] trial_limit;
        logic [39:0] flash_time;
        logic [39:0] dark_time;
        logic [39:0] repetition_rest_time;
        logic [39:0] trial_rest_time;
        logic [31:0] start_code;
    } cfg_t;

    typedef struct packed {
        logic        is_tick;
        logic [63:0] now;
    } qword_t;

    typedef struct packed {
        logic        start;
        logic [63:0] dividend;
        logic [47:0] divisor;
        logic [6:0]  steps;
    } div_req_t;

    typedef struct packed {
        logic        done;
        logic [63:0] quot;
        logic [47:0] rem;
    } div_rsp_t;

    function automatic logic [39:0] eff_rest(input logic [39:0] v);
        return (v < MIN_REST) ? MIN_REST : v;
    endfunction

    function automatic logic [4:0] eff_grid(input logic [4:0] v);
        logic [4:0] r;
        r = v;
        if (v == 5'd0)
            r = 5'd1;
        else if (v > 5'(MAX_GRID))
            r = 5'(MAX_GRID);
        return r;
    endfunction

endpackage

FILE: rtl/core/flash_stimulus_sequencer_core.sv
`timescale 1ns / 1ps
// Flash stimulus sequencer top level: configuration registers, front end and back end.
//
// Input channel (in_valid/in_stall) takes one word per tick or external event:
// operation 0 is a time tick, 1 an event whose code may arm the sequencer.
// Output channel (out_valid/out_stall) gives 0 to 5 event words per tick, the
// final one of a burst flagged by last. Configuration writes go over
// cfg_valid/cfg_ready (always ready), cfg_index selecting the register.
// A two-word queue sits between the input side and the sequencing engine, so
// input words are still taken while the engine works or the output is stalled.
// Per armed tick the engine does the pop, duration products and trial compare,
// then the elapsed-time modulo and the flash slot divide in the shared
// one-bit-per-cycle divider (skipped in a trial rest or past the trial end,
// the second also in a repetition rest), then builds the burst and emits
// one event word at a time. Entering a repetition rest adds a reshuffle of
// 2 * grid picks plus a setup state per order. Events and unarmed ticks
// are only popped. Reset restores the default configuration, clears arming
// and sets the identity orders. A stalled receiver holds the burst; the
// queue then fills and in_stall rises.
module flash_stimulus_sequencer_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        operation,
    input  logic [63:0] now,
    input  logic [31:0] event_code,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [3:0]  event_kind,
    output logic [3:0]  label_index,
    output logic [63:0] event_time,
    output logic        last,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [39:0] cfg_data
);

    fss_pkg::cfg_t   cfg_reg;
    fss_pkg::qword_t q_word;
    logic            q_valid;
    logic            pop;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.grid_size             <= 5'd6;
            cfg_reg.repetitions_per_trial <= 8'd10;
            cfg_reg.trial_limit           <= 16'd0;
            cfg_reg.flash_time            <= 40'd858993459;
            cfg_reg.dark_time             <= 40'd429496729;
            cfg_reg.repetition_rest_time  <= 40'd42949672;
            cfg_reg.trial_rest_time       <= 40'd4294967296;
            cfg_reg.start_code            <= 32'd0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                fss_pkg::CFG_GRID:       cfg_reg.grid_size             <= cfg_data[4:0];
                fss_pkg::CFG_REPS:       cfg_reg.repetitions_per_trial <= cfg_data[7:0];
                fss_pkg::CFG_LIMIT:      cfg_reg.trial_limit           <= cfg_data[15:0];
                fss_pkg::CFG_FLASH:      cfg_reg.flash_time            <= cfg_data;
                fss_pkg::CFG_DARK:       cfg_reg.dark_time             <= cfg_data;
                fss_pkg::CFG_REP_REST:   cfg_reg.repetition_rest_time  <= cfg_data;
                fss_pkg::CFG_TRIAL_REST: cfg_reg.trial_rest_time       <= cfg_data;
                fss_pkg::CFG_START:      cfg_reg.start_code            <= cfg_data[31:0];
                default: ;
            endcase
        end
    end

    fss_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .operation  (operation),
        .now        (now),
        .event_code (event_code),
        .start_code (cfg_reg.start_code),
        .pop        (pop),
        .q_valid    (q_valid),
        .q_word     (q_word)
    );

    fss_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_reg),
        .q_valid     (q_valid),
        .q_word      (q_word),
        .pop         (pop),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .event_kind  (event_kind),
        .label_index (label_index),
        .event_time  (event_time),
        .last        (last)
    );

    a_pop_needs_word: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> q_valid)
        else $error("queue popped while empty");

    a_full_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> q_valid)
        else $error("queue full but reports no word");

    a_stall_after_push: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(in_stall) |-> $past(in_valid))
        else $error("queue filled without an input word");

endmodule

FILE: rtl/core/fss_front.sv
`timescale 1ns / 1ps
// Input side: accepts words, drops non-start events, two-entry queue to the back end.
module fss_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic                operation,
    input  logic [63:0]         now,
    input  logic [31:0]         event_code,
    input  logic [31:0]         start_code,
    input  logic                pop,
    output logic                q_valid,
    output fss_pkg::qword_t     q_word
);

    fss_pkg::qword_t mem_reg [2];
    logic            wr_ptr_reg;
    logic            rd_ptr_reg;
    logic [1:0]      count_reg;
    logic            push;
    logic            do_pop;

    assign in_stall = (count_reg == 2'd2);
    assign q_valid  = (count_reg != 2'd0);
    assign q_word   = mem_reg[rd_ptr_reg];
    assign push     = in_valid && !in_stall
                      && ((operation == fss_pkg::OP_TICK) || (event_code == start_code));
    assign do_pop   = pop && q_valid;

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg].is_tick <= (operation == fss_pkg::OP_TICK);
            mem_reg[wr_ptr_reg].now     <= now;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= !wr_ptr_reg;
            if (do_pop)
                rd_ptr_reg <= !rd_ptr_reg;
            if (push && !do_pop)
                count_reg <= count_reg + 2'd1;
            else if (!push && do_pop)
                count_reg <= count_reg - 2'd1;
        end
    end

endmodule

FILE: rtl/core/fss_div.sv
`timescale 1ns / 1ps
// Shared restoring divider, one quotient bit per cycle over the top bits of the dividend.
module fss_div (
    input  logic                clk,
    input  logic                rst_n,
    input  fss_pkg::div_req_t   req,
    output fss_pkg::div_rsp_t   rsp
);

    logic [63:0] dvd_reg;
    logic [63:0] quot_reg;
    logic [47:0] rem_reg;
    logic [47:0] divisor_reg;
    logic [6:0]  cnt_reg;
    logic        busy_reg;
    logic        done_reg;
    logic [48:0] trial;
    logic [48:0] diff;
    logic        ge;

    assign trial = {rem_reg, dvd_reg[63]};
    assign ge    = (trial >= {1'b0, divisor_reg});
    assign diff  = trial - {1'b0, divisor_reg};

    assign rsp.done = done_reg;
    assign rsp.quot = quot_reg;
    assign rsp.rem  = rem_reg;

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            dvd_reg     <= req.dividend;
            divisor_reg <= req.divisor;
            rem_reg     <= '0;
            quot_reg    <= '0;
        end
        else if (busy_reg)
        begin
            dvd_reg  <= {dvd_reg[62:0], 1'b0};
            rem_reg  <= ge ? diff[47:0] : trial[47:0];
            quot_reg <= {quot_reg[62:0], ge};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                cnt_reg  <= req.steps;
                busy_reg <= 1'b1;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 7'd1;
                if (cnt_reg == 7'd1)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

endmodule

FILE: rtl/core/fss_back.sv
`timescale 1ns / 1ps
// Back end: phase computation, event burst, reshuffle and the output register.
module fss_back (
    input  logic                clk,
    input  logic                rst_n,
    input  fss_pkg::cfg_t       cfg,
    input  logic                q_valid,
    input  fss_pkg::qword_t     q_word,
    output logic                pop,
    output logic                out_valid,
    input  logic                out_stall,
    output logic [3:0]          event_kind,
    output logic [3:0]          label_index,
    output logic [63:0]         event_time,
    output logic                last
);

    typedef enum logic [11:0] {
        S_IDLE    = 12'b000000000001,
        S_MUL1    = 12'b000000000010,
        S_MUL2    = 12'b000000000100,
        S_MUL3    = 12'b000000001000,
        S_CMP     = 12'b000000010000,
        S_DIV1    = 12'b000000100000,
        S_DIV2    = 12'b000001000000,
        S_BURST   = 12'b000010000000,
        S_EMIT    = 12'b000100000000,
        S_SH_INIT = 12'b001000000000,
        S_SH_STEP = 12'b010000000000,
        S_SH_WAIT = 12'b100000000000
    } state_t;

    function automatic logic [42:0] push_ev(input logic [39:0] l, input logic [2:0] c,
                                            input logic [7:0] e);
        logic [42:0] r;
        r = {l, c};
        if (c < 3'd5)
            r = {l[31:0], e, c + 3'd1};
        return r;
    endfunction

    state_t      state_reg, state_next;
    logic        armed_reg, armed_next;
    logic [63:0] trial_start_reg, trial_start_next;
    logic [15:0] trial_number_reg, trial_number_next;
    logic [2:0]  prev_phase_reg, prev_phase_next;
    logic [3:0]  row_order_reg [16];
    logic [3:0]  row_order_next [16];
    logic [3:0]  col_order_reg [16];
    logic [3:0]  col_order_next [16];
    logic [3:0]  pool_reg [16];
    logic [3:0]  pool_next [16];
    logic [15:0] lfsr_reg, lfsr_next;
    logic [63:0] now_reg, now_next;
    logic [40:0] period_reg, period_next;
    logic [46:0] rep_dur_reg, rep_dur_next;
    logic [47:0] rep_total_reg, rep_total_next;
    logic [55:0] trial_dur_reg, trial_dur_next;
    logic [2:0]  phase_reg, phase_next;
    logic        is_row_reg, is_row_next;
    logic [3:0]  label_reg, label_next;
    logic [39:0] burst_reg, burst_next;
    logic [2:0]  burst_cnt_reg, burst_cnt_next;
    logic [4:0]  left_reg, left_next;
    logic [3:0]  pick_reg, pick_next;
    logic        sh_col_reg, sh_col_next;
    logic        out_valid_reg, out_valid_next;
    logic [3:0]  kind_reg, kind_next;
    logic [3:0]  lbl_reg, lbl_next;
    logic [63:0] time_reg, time_next;
    logic        last_reg, last_next;

    fss_pkg::div_req_t div_req;
    fss_pkg::div_rsp_t div_rsp;

    logic [4:0]  g;
    logic [40:0] period_sum;
    logic [63:0] tit;

    fss_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    assign g          = fss_pkg::eff_grid(cfg.grid_size);
    assign period_sum = {1'b0, cfg.flash_time} + {1'b0, cfg.dark_time};
    assign tit        = now_reg - trial_start_reg;

    assign out_valid   = out_valid_reg;
    assign event_kind  = kind_reg;
    assign label_index = lbl_reg;
    assign event_time  = time_reg;
    assign last        = last_reg;

    always_comb
    begin
        logic [39:0] l;
        logic [2:0]  c;
        logic [2:0]  sel;
        logic [3:0]  j;
        logic [3:0]  slot;
        logic [15:0] lf;

        state_next        = state_reg;
        armed_next        = armed_reg;
        trial_start_next  = trial_start_reg;
        trial_number_next = trial_number_reg;
        prev_phase_next   = prev_phase_reg;
        row_order_next    = row_order_reg;
        col_order_next    = col_order_reg;
        pool_next         = pool_reg;
        lfsr_next         = lfsr_reg;
        now_next          = now_reg;
        period_next       = period_reg;
        rep_dur_next      = rep_dur_reg;
        rep_total_next    = rep_total_reg;
        trial_dur_next    = trial_dur_reg;
        phase_next        = phase_reg;
        is_row_next       = is_row_reg;
        label_next        = label_reg;
        burst_next        = burst_reg;
        burst_cnt_next    = burst_cnt_reg;
        left_next         = left_reg;
        pick_next         = pick_reg;
        sh_col_next       = sh_col_reg;
        kind_next         = kind_reg;
        lbl_next          = lbl_reg;
        time_next         = time_reg;
        last_next         = last_reg;
        out_valid_next    = out_valid_reg && out_stall;
        pop               = 1'b0;
        div_req           = '0;
        l                 = '0;
        c                 = '0;
        sel               = burst_cnt_reg - 3'd1;
        j                 = div_rsp.rem[3:0];
        slot              = div_rsp.quot[4:1];
        lf                = {1'b0, lfsr_reg[15:1]} ^ (lfsr_reg[0] ? fss_pkg::LFSR_TAPS : 16'd0);

        unique case (state_reg)
            S_IDLE:
            begin
                if (q_valid)
                begin
                    pop = 1'b1;
                    if (!q_word.is_tick)
                    begin
                        if (!armed_reg)
                        begin
                            armed_next       = 1'b1;
                            trial_start_next = q_word.now
                                + 64'(fss_pkg::eff_rest(cfg.trial_rest_time));
                        end
                    end
                    else if (armed_reg)
                    begin
                        now_next   = q_word.now;
                        state_next = S_MUL1;
                    end
                end
            end
            S_MUL1:
            begin
                period_next  = period_sum;
                rep_dur_next = 47'({g, 1'b0}) * 47'(period_sum);
                state_next   = S_MUL2;
            end
            S_MUL2:
            begin
                rep_total_next = 48'(rep_dur_reg)
                    + 48'(fss_pkg::eff_rest(cfg.repetition_rest_time));
                state_next     = S_MUL3;
            end
            S_MUL3:
            begin
                trial_dur_next = 56'(cfg.repetitions_per_trial) * 56'(rep_total_reg);
                state_next     = S_CMP;
            end
            S_CMP:
            begin
                is_row_next = 1'b0;
                label_next  = 4'd0;
                if (now_reg < trial_start_reg)
                begin
                    phase_next = fss_pkg::PH_TRIALREST;
                    state_next = S_BURST;
                end
                else if (tit >= 64'(trial_dur_reg))
                begin
                    if (cfg.trial_limit == 16'd0 || trial_number_reg < cfg.trial_limit)
                    begin
                        trial_start_next  = now_reg
                            + 64'(fss_pkg::eff_rest(cfg.trial_rest_time));
                        trial_number_next = trial_number_reg + 16'd1;
                        phase_next        = fss_pkg::PH_TRIALREST;
                    end
                    else
                        phase_next = fss_pkg::PH_NONE;
                    state_next = S_BURST;
                end
                else
                begin
                    div_req.start    = 1'b1;
                    div_req.dividend = tit;
                    div_req.divisor  = rep_total_reg;
                    div_req.steps    = 7'd64;
                    state_next       = S_DIV1;
                end
            end
            S_DIV1:
            begin
                if (div_rsp.done)
                begin
                    if (div_rsp.rem >= 48'(rep_dur_reg))
                    begin
                        phase_next = fss_pkg::PH_REPREST;
                        state_next = S_BURST;
                    end
                    else
                    begin
                        div_req.start    = 1'b1;
                        div_req.dividend = {div_rsp.rem, 16'd0};
                        div_req.divisor  = 48'(period_reg);
                        div_req.steps    = 7'd48;
                        state_next       = S_DIV2;
                    end
                end
            end
            S_DIV2:
            begin
                if (div_rsp.done)
                begin
                    phase_next  = (div_rsp.rem < 48'(cfg.flash_time))
                                  ? fss_pkg::PH_FLASH : fss_pkg::PH_DARK;
                    is_row_next = div_rsp.quot[0];
                    label_next  = div_rsp.quot[0] ? row_order_reg[slot] : col_order_reg[slot];
                    state_next  = S_BURST;
                end
            end
            S_BURST:
            begin
                if (phase_reg == prev_phase_reg)
                    state_next = S_IDLE;
                else
                begin
                    case (prev_phase_reg)
                        fss_pkg::PH_FLASH:
                            {l, c} = push_ev(l, c, {fss_pkg::EV_FLASH_OFF, 4'd0});
                        fss_pkg::PH_REPREST:
                            if (phase_reg != fss_pkg::PH_TRIALREST
                                && phase_reg != fss_pkg::PH_NONE)
                                {l, c} = push_ev(l, c, {fss_pkg::EV_SEG_START, 4'd0});
                        fss_pkg::PH_TRIALREST:
                        begin
                            {l, c} = push_ev(l, c, {fss_pkg::EV_REST_STOP, 4'd0});
                            {l, c} = push_ev(l, c, {fss_pkg::EV_TRIAL_START, 4'd0});
                            {l, c} = push_ev(l, c, {fss_pkg::EV_SEG_START, 4'd0});
                        end
                        fss_pkg::PH_NONE:
                            {l, c} = push_ev(l, c, {fss_pkg::EV_EXP_START, 4'd0});
                        default: ;
                    endcase
                    case (phase_reg)
                        fss_pkg::PH_FLASH:
                        begin
                            {l, c} = push_ev(l, c, {is_row_reg ? fss_pkg::EV_ROW_LABEL
                                                    : fss_pkg::EV_COL_LABEL, label_reg});
                            {l, c} = push_ev(l, c, {fss_pkg::EV_FLASH_ON, 4'd0});
                        end
                        fss_pkg::PH_REPREST:
                            {l, c} = push_ev(l, c, {fss_pkg::EV_SEG_STOP, 4'd0});
                        fss_pkg::PH_TRIALREST:
                        begin
                            if (prev_phase_reg != fss_pkg::PH_NONE)
                            begin
                                if (prev_phase_reg != fss_pkg::PH_REPREST)
                                    {l, c} = push_ev(l, c, {fss_pkg::EV_SEG_STOP, 4'd0});
                                {l, c} = push_ev(l, c, {fss_pkg::EV_TRIAL_STOP, 4'd0});
                            end
                            {l, c} = push_ev(l, c, {fss_pkg::EV_REST_START, 4'd0});
                        end
                        fss_pkg::PH_NONE:
                        begin
                            if (prev_phase_reg != fss_pkg::PH_REPREST)
                                {l, c} = push_ev(l, c, {fss_pkg::EV_SEG_STOP, 4'd0});
                            {l, c} = push_ev(l, c, {fss_pkg::EV_TRIAL_STOP, 4'd0});
                            {l, c} = push_ev(l, c, {fss_pkg::EV_EXP_STOP, 4'd0});
                        end
                        default: ;
                    endcase
                    burst_next      = l;
                    burst_cnt_next  = c;
                    prev_phase_next = phase_reg;
                    state_next      = S_EMIT;
                end
            end
            S_EMIT:
            begin
                if (burst_cnt_reg == 3'd0)
                begin
                    sh_col_next = 1'b0;
                    state_next  = (phase_reg == fss_pkg::PH_REPREST) ? S_SH_INIT : S_IDLE;
                end
                else if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    kind_next      = burst_reg[sel * 8 + 4 +: 4];
                    lbl_next       = burst_reg[sel * 8 +: 4];
                    time_next      = now_reg;
                    last_next      = (burst_cnt_reg == 3'd1);
                    burst_cnt_next = sel;
                end
            end
            S_SH_INIT:
            begin
                for (int k = 0; k < fss_pkg::MAX_GRID; k++)
                    pool_next[k] = 4'(k);
                left_next  = g;
                pick_next  = 4'd0;
                state_next = S_SH_STEP;
            end
            S_SH_STEP:
            begin
                lfsr_next        = lf;
                div_req.start    = 1'b1;
                div_req.dividend = {lf, 48'd0};
                div_req.divisor  = 48'(left_reg);
                div_req.steps    = 7'd16;
                state_next       = S_SH_WAIT;
            end
            S_SH_WAIT:
            begin
                if (div_rsp.done)
                begin
                    if (sh_col_reg)
                        col_order_next[pick_reg] = pool_reg[j];
                    else
                        row_order_next[pick_reg] = pool_reg[j];
                    for (int k = 0; k < fss_pkg::MAX_GRID - 1; k++)
                        if (4'(k) >= j)
                            pool_next[k] = pool_reg[k + 1];
                    left_next = left_reg - 5'd1;
                    pick_next = pick_reg + 4'd1;
                    if ({1'b0, pick_reg} + 5'd1 == g)
                    begin
                        sh_col_next = 1'b1;
                        state_next  = sh_col_reg ? S_IDLE : S_SH_INIT;
                    end
                    else
                        state_next = S_SH_STEP;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk)
    begin
        pool_reg      <= pool_next;
        now_reg       <= now_next;
        period_reg    <= period_next;
        rep_dur_reg   <= rep_dur_next;
        rep_total_reg <= rep_total_next;
        trial_dur_reg <= trial_dur_next;
        is_row_reg    <= is_row_next;
        label_reg     <= label_next;
        burst_reg     <= burst_next;
        left_reg      <= left_next;
        pick_reg      <= pick_next;
        kind_reg      <= kind_next;
        lbl_reg       <= lbl_next;
        time_reg      <= time_next;
        last_reg      <= last_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            armed_reg        <= 1'b0;
            trial_start_reg  <= 64'(fss_pkg::eff_rest(40'h01_0000_0000));
            trial_number_reg <= 16'd1;
            prev_phase_reg   <= fss_pkg::PH_NONE;
            for (int k = 0; k < fss_pkg::MAX_GRID; k++)
            begin
                row_order_reg[k] <= 4'(k);
                col_order_reg[k] <= 4'(k);
            end
            lfsr_reg         <= fss_pkg::LFSR_SEED;
            phase_reg        <= fss_pkg::PH_NONE;
            burst_cnt_reg    <= 3'd0;
            sh_col_reg       <= 1'b0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            armed_reg        <= armed_next;
            trial_start_reg  <= trial_start_next;
            trial_number_reg <= trial_number_next;
            prev_phase_reg   <= prev_phase_next;
            row_order_reg    <= row_order_next;
            col_order_reg    <= col_order_next;
            lfsr_reg         <= lfsr_next;
            phase_reg        <= phase_next;
            burst_cnt_reg    <= burst_cnt_next;
            sh_col_reg       <= sh_col_next;
            out_valid_reg    <= out_valid_next;
        end
    end

endmodule

FILE: tb/sv/tb_flash_stimulus_sequencer_core.sv
`timescale 1ns / 1ps
// Self-checking testbench of the flash stimulus sequencer core with its own phase predictor.
module tb_flash_stimulus_sequencer_core;
    import fss_pkg::*;

    typedef struct {
        logic        op;
        logic [63:0] at;
        logic [31:0] code;
    } word_t;

    typedef struct {
        logic [3:0]  kind;
        logic [3:0]  lbl;
        logic [63:0] at;
        logic        fin;
    } flash_ev_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic        operation;
    logic [63:0] now;
    logic [31:0] event_code;
    logic        out_valid;
    logic        out_stall;
    logic [3:0]  event_kind;
    logic [3:0]  label_index;
    logic [63:0] event_time;
    logic        last;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [2:0]  cfg_index;
    logic [39:0] cfg_data;

    flash_stimulus_sequencer_core DUT (.*);

    word_t       pending_words[$];
    flash_ev_t   expected_events[$];
    flash_ev_t   burst[$];
    int          errors;
    bit          taken;
    bit          no_idle;
    int          hold_req;
    int          quiet_cycles;

    // predictor state
    cfg_t        shadow;
    bit          armed_q;
    logic [63:0] trial_begin;
    logic [15:0] trial_count;
    logic [2:0]  last_phase;
    logic [3:0]  rows [MAX_GRID];
    logic [3:0]  cols [MAX_GRID];
    logic [15:0] lfsr_q;

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    function automatic logic [63:0] rest_of(input logic [39:0] v);
        return (v < MIN_REST) ? 64'(MIN_REST) : 64'(v);
    endfunction

    function automatic int grid_of();
        if (shadow.grid_size == 5'd0)
            return 1;
        if (shadow.grid_size > 5'(MAX_GRID))
            return MAX_GRID;
        return int'(shadow.grid_size);
    endfunction

    function automatic void add_event(input logic [3:0] kind, input logic [3:0] lbl,
                                      input logic [63:0] t);
        flash_ev_t e;
        if (burst.size() >= 5)
            return;
        e.kind = kind;
        e.lbl  = lbl;
        e.at   = t;
        e.fin  = 1'b0;
        burst.insert(burst.size(), e);
    endfunction

    function automatic void shuffle_into(input bit to_rows, input int g);
        logic [3:0] pool [MAX_GRID];
        int         left;
        int         j;
        left = g;
        for (int i = 0; i < g; i++)
            pool[i] = 4'(i);
        for (int i = 0; i < g; i++)
        begin
            lfsr_q = lfsr_q[0] ? ((lfsr_q >> 1) ^ LFSR_TAPS) : (lfsr_q >> 1);
            j = int'(lfsr_q) % left;
            if (to_rows)
                rows[i] = pool[j];
            else
                cols[i] = pool[j];
            for (int k = j; k + 1 < left; k++)
                pool[k] = pool[k + 1];
            left--;
        end
    endfunction

    function automatic void predict_word(input word_t w);
        int          g;
        logic [63:0] period;
        logic [63:0] rep_dur;
        logic [63:0] rep_total;
        logic [63:0] trial_dur;
        logic [63:0] tit;
        logic [63:0] tir;
        logic [63:0] idx;
        logic [2:0]  phase;
        logic [2:0]  prev;
        bit          is_row;
        logic [3:0]  lbl;
        flash_ev_t   e;
        g = grid_of();
        period = 64'(shadow.flash_time) + 64'(shadow.dark_time);
        rep_dur = 64'(2 * g) * period;
        rep_total = rep_dur + rest_of(shadow.repetition_rest_time);
        trial_dur = 64'(shadow.repetitions_per_trial) * rep_total;
        prev = last_phase;
        is_row = 0;
        lbl = 4'd0;
        burst.delete();
        if (w.op != OP_TICK)
        begin
            if (!armed_q && w.code == shadow.start_code)
            begin
                trial_begin = w.at + rest_of(shadow.trial_rest_time);
                armed_q = 1;
            end
            return;
        end
        if (!armed_q)
            return;
        if (w.at < trial_begin)
            phase = PH_TRIALREST;
        else
        begin
            tit = w.at - trial_begin;
            if (tit >= trial_dur)
            begin
                if (shadow.trial_limit == 16'd0 || trial_count < shadow.trial_limit)
                begin
                    trial_begin = w.at + rest_of(shadow.trial_rest_time);
                    trial_count = trial_count + 16'd1;
                    phase = PH_TRIALREST;
                end
                else
                    phase = PH_NONE;
            end
            else
            begin
                tir = tit % rep_total;
                if (tir >= rep_dur)
                    phase = PH_REPREST;
                else
                begin
                    idx = tir / period;
                    phase = ((tir % period) < 64'(shadow.flash_time)) ? PH_FLASH : PH_DARK;
                    is_row = idx[0];
                    if ((idx >> 1) < MAX_GRID)
                        lbl = is_row ? rows[idx[4:1]] : cols[idx[4:1]];
                end
            end
        end
        if (phase == prev)
            return;
        case (prev)
            PH_FLASH: add_event(EV_FLASH_OFF, 4'd0, w.at);
            PH_REPREST:
                if (phase != PH_TRIALREST && phase != PH_NONE)
                    add_event(EV_SEG_START, 4'd0, w.at);
            PH_TRIALREST:
            begin
                add_event(EV_REST_STOP, 4'd0, w.at);
                add_event(EV_TRIAL_START, 4'd0, w.at);
                add_event(EV_SEG_START, 4'd0, w.at);
            end
            PH_NONE: add_event(EV_EXP_START, 4'd0, w.at);
            default: ;
        endcase
        case (phase)
            PH_FLASH:
            begin
                add_event(is_row ? EV_ROW_LABEL : EV_COL_LABEL, lbl, w.at);
                add_event(EV_FLASH_ON, 4'd0, w.at);
            end
            PH_REPREST:
            begin
                add_event(EV_SEG_STOP, 4'd0, w.at);
                shuffle_into(1, g);
                shuffle_into(0, g);
            end
            PH_TRIALREST:
            begin
                if (prev != PH_NONE)
                begin
                    if (prev != PH_REPREST)
                        add_event(EV_SEG_STOP, 4'd0, w.at);
                    add_event(EV_TRIAL_STOP, 4'd0, w.at);
                end
                add_event(EV_REST_START, 4'd0, w.at);
            end
            PH_NONE:
            begin
                if (prev != PH_REPREST)
                    add_event(EV_SEG_STOP, 4'd0, w.at);
                add_event(EV_TRIAL_STOP, 4'd0, w.at);
                add_event(EV_EXP_STOP, 4'd0, w.at);
            end
            default: ;
        endcase
        last_phase = phase;
        for (int i = 0; i < burst.size(); i++)
        begin
            e = burst[i];
            e.fin = (i == burst.size() - 1);
            expected_events.insert(expected_events.size(), e);
        end
    endfunction

    // input driver
    always @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            predict_word('{operation, now, event_code});
            taken = 1;
        end
    end

    always @(negedge clk)
    begin
        word_t w;
        if (rst_n && (!in_valid || taken))
        begin
            taken = 0;
            if (pending_words.size() > 0 && (no_idle || $urandom_range(99) >= 21))
            begin
                w = pending_words.pop_front();
                operation  <= w.op;
                now        <= w.at;
                event_code <= w.code;
                in_valid   <= 1'b1;
            end
            else
                in_valid <= 1'b0;
        end
    end

    // output side
    always @(negedge clk)
    begin
        if (hold_req > 0)
        begin
            hold_req  = hold_req - 1;
            out_stall <= 1'b1;
        end
        else
            out_stall <= !no_idle && ($urandom_range(99) < 21);
    end

    always @(posedge clk)
    begin
        flash_ev_t e;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_events.size() == 0)
            begin
                $display("%0t unexpected word kind=%0d label=%0d time=%h last=%0d", $time,
                         event_kind, label_index, event_time, last);
                errors++;
            end
            else
            begin
                e = expected_events.pop_front();
                if (event_kind !== e.kind)
                begin
                    $display("%0t event_kind expected %0d actual %0d", $time, e.kind, event_kind);
                    errors++;
                end
                if (label_index !== e.lbl)
                begin
                    $display("%0t label_index expected %0d actual %0d", $time, e.lbl, label_index);
                    errors++;
                end
                if (event_time !== e.at)
                begin
                    $display("%0t event_time expected %h actual %h", $time, e.at, event_time);
                    errors++;
                end
                if (last !== e.fin)
                begin
                    $display("%0t last expected %0d actual %0d", $time, e.fin, last);
                    errors++;
                end
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > 6000)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    task automatic cfg_write(input logic [2:0] idx, input logic [39:0] data);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            CFG_GRID:       shadow.grid_size = data[4:0];
            CFG_REPS:       shadow.repetitions_per_trial = data[7:0];
            CFG_LIMIT:      shadow.trial_limit = data[15:0];
            CFG_FLASH:      shadow.flash_time = data;
            CFG_DARK:       shadow.dark_time = data;
            CFG_REP_REST:   shadow.repetition_rest_time = data;
            CFG_TRIAL_REST: shadow.trial_rest_time = data;
            default:        shadow.start_code = data[31:0];
        endcase
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic drain();
        while (pending_words.size() > 0 || in_valid || expected_events.size() > 0)
            @(posedge clk);
        repeat (1500) @(posedge clk);
    endtask

    task automatic add_word(input logic op, input logic [63:0] t, input logic [31:0] code);
        word_t w;
        w.op   = op;
        w.at   = t;
        w.code = code;
        pending_words.insert(pending_words.size(), w);
    endtask

    initial
    begin
        logic [63:0] t;
        logic [63:0] unit;
        logic [63:0] r64;
        logic [39:0] vals [8];
        int          sel;
        errors = 0;
        taken = 0;
        no_idle = 0;
        hold_req = 0;
        quiet_cycles = 0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        operation = OP_TICK;
        now = '0;
        event_code = '0;
        out_stall = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = CFG_GRID;
        cfg_data = '0;
        shadow = '{5'd6, 8'd10, 16'd0, 40'd858993459, 40'd429496729, 40'd42949672,
                   40'd4294967296, 32'd0};
        armed_q = 0;
        trial_begin = 64'(shadow.trial_rest_time);
        trial_count = 16'd1;
        last_phase = PH_NONE;
        for (int i = 0; i < MAX_GRID; i++)
        begin
            rows[i] = 4'(i);
            cols[i] = 4'(i);
        end
        lfsr_q = LFSR_SEED;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // default settings: arming, first flashes, repetition rest, wrap of now
        add_word(~OP_TICK, 64'd0, 32'd5);
        add_word(OP_TICK, 64'd100, 32'd0);
        add_word(~OP_TICK, 64'd0, 32'd0);
        add_word(~OP_TICK, 64'd7, 32'hFFFF_FFFF);
        add_word(OP_TICK, 64'd0, 32'd0);
        add_word(OP_TICK, 64'h1_0000_0001, 32'd0);
        add_word(OP_TICK, 64'h1_0000_0000 + 64'd1000000000, 32'd0);
        add_word(OP_TICK, 64'h1_0000_0000 + 64'd1288490189, 32'd0);
        add_word(OP_TICK, 64'h1_0000_0000 + 64'd15461882270, 32'd0);
        add_word(OP_TICK, 64'h1_0000_0000 + 64'd15504831945, 32'd0);
        add_word(OP_TICK, 64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF);
        add_word(OP_TICK, 64'd5, 32'd0);
        drain();

        for (int ph = 0; ph < 6; ph++)
        begin
            case (ph)
                0: vals = '{40'd2, 40'd2, 40'd0, 40'd20000000, 40'd10000000, 40'd42949672,
                            40'd42949672, 40'($urandom)};
                1: vals = '{40'd0, 40'd1, 40'd3, 40'd0, 40'd0, 40'd0, 40'd5,
                            40'hFF_FFFF_FFFF};
                2: vals = '{40'd31, 40'd255, 40'd65535, 40'hFF_FFFF_FFFF, 40'd0,
                            40'hFF_FFFF_FFFF, 40'hFF_FFFF_FFFF, 40'd0};
                3: vals = '{40'd16, 40'd0, 40'd1, 40'd3000000, 40'd1000000, 40'd42949672,
                            40'd50000000, 40'd1};
                4: vals = '{40'd3, 40'd3, 40'd0, 40'd5000000, 40'd5000000,
                            40'($urandom_range(100000000, 42949672)), 40'd60000000,
                            40'($urandom)};
                default: vals = '{40'($urandom_range(31)), 40'($urandom_range(4)),
                                  40'($urandom_range(8)), 40'($urandom_range(40000000)),
                                  40'($urandom_range(40000000)),
                                  40'($urandom_range(90000000)),
                                  40'($urandom_range(90000000)), 40'($urandom)};
            endcase
            for (int i = 0; i < 8; i++)
                cfg_write(3'(i), vals[i]);
            unit = 64'(shadow.flash_time) + 64'(shadow.dark_time);
            if (unit < 64'(MIN_REST))
                unit = 64'(MIN_REST);
            no_idle = (ph == 4);
            t = trial_begin - 64'(MIN_REST);
            for (int n = 0; n < 52; n++)
            begin
                if (ph == 0 && n == 20)
                    hold_req = 400;
                sel = $urandom_range(99);
                r64 = {$urandom, $urandom};
                if (sel < 8)
                    add_word(~OP_TICK, r64, $urandom);
                else if (sel < 14)
                begin
                    t = r64;
                    add_word(OP_TICK, t, $urandom);
                end
                else
                begin
                    t = t + (r64 % (sel < 85 ? unit : unit * 4)) + 64'd1;
                    add_word(OP_TICK, t, $urandom);
                end
            end
            drain();
            no_idle = 0;
        end

        repeat (200) @(posedge clk);
        if (errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
